### hdl/typed_integer_alu_top_assert.svh
// Assertion macros used by the typed integer ALU top file.
`ifndef TYPED_INTEGER_ALU_TOP_ASSERT_SVH
`define TYPED_INTEGER_ALU_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TIA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TIA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tia_pkg.sv
// ----------------------------------------------------------------------------
// tia_pkg
// Types, opcodes and helpers shared by the typed integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package tia_pkg;

    localparam int DataW     = 64;
    localparam int DivSteps  = 64;
    localparam int NumStg    = DivSteps + 4;
    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;
    localparam int CntW      = 3;
    localparam int InTdataW  = 144;

    localparam logic [4:0] CMD_ADD     = 5'd0;
    localparam logic [4:0] CMD_SUB     = 5'd1;
    localparam logic [4:0] CMD_MUL     = 5'd2;
    localparam logic [4:0] CMD_DIV     = 5'd3;
    localparam logic [4:0] CMD_MOD     = 5'd4;
    localparam logic [4:0] CMD_AND     = 5'd5;
    localparam logic [4:0] CMD_OR      = 5'd6;
    localparam logic [4:0] CMD_XOR     = 5'd7;
    localparam logic [4:0] CMD_BITNOT  = 5'd8;
    localparam logic [4:0] CMD_NEG     = 5'd9;
    localparam logic [4:0] CMD_SHL     = 5'd10;
    localparam logic [4:0] CMD_SHR     = 5'd11;
    localparam logic [4:0] CMD_EQ      = 5'd12;
    localparam logic [4:0] CMD_NE      = 5'd13;
    localparam logic [4:0] CMD_LT      = 5'd14;
    localparam logic [4:0] CMD_LE      = 5'd15;
    localparam logic [4:0] CMD_GT      = 5'd16;
    localparam logic [4:0] CMD_GE      = 5'd17;
    localparam logic [4:0] CMD_LNOT    = 5'd18;
    localparam logic [4:0] CMD_CAST    = 5'd19;
    localparam logic [4:0] CMD_BITCAST = 5'd20;
    localparam logic [4:0] CMD_BOX     = 5'd21;

    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_MUL,
        KIND_DIV,
        KIND_MOD
    } t_kind;

    // One classified request as it waits in the queue
    typedef struct packed {
        t_kind             kind;
        logic [1:0]        wc;
        logic              sgn;
        logic              ext;
        logic              na;
        logic              nb;
        logic              dz;
        logic [DataW-1:0]  opa;
        logic [DataW-1:0]  opb;
        logic [DataW-1:0]  res;
    } t_entry;

    // One slot of the execution pipeline
    typedef struct packed {
        logic              vld;
        t_entry            e;
        logic [DataW-1:0]  rem;
    } t_stage;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [CntW-1:0]   count;
    } t_fifo_stat;

    // Low bits of v at the coded width, sign- or zero-extended to 64 bits
    function automatic logic [DataW-1:0] ext_w(input logic [DataW-1:0] v,
                                               input logic [1:0] wc,
                                               input logic s);
        logic [DataW-1:0] r;
        unique case (wc)
            WC_8:    r = {{56{s & v[7]}},  v[7:0]};
            WC_16:   r = {{48{s & v[15]}}, v[15:0]};
            WC_32:   r = {{32{s & v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [DataW-1:0] mask_w(input logic [1:0] wc);
        logic [DataW-1:0] r;
        unique case (wc)
            WC_8:    r = 64'h0000_0000_0000_00FF;
            WC_16:   r = 64'h0000_0000_0000_FFFF;
            WC_32:   r = 64'h0000_0000_FFFF_FFFF;
            default: r = '1;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] bits_w(input logic [1:0] wc);
        return 7'(7'd8 << wc);
    endfunction

endpackage

`default_nettype wire

### hdl/tia_front.sv
// ----------------------------------------------------------------------------
// tia_front
// Decodes a request, extends the operands and settles every simple
// operation; multiply and divide leave with prepared operands.
// ----------------------------------------------------------------------------
`default_nettype none

module tia_front (
    input  wire logic [4:0]            i_cmd,
    input  wire logic [1:0]            i_wc,
    input  wire logic                  i_sgn,
    input  wire logic [1:0]            i_swc,
    input  wire logic                  i_ssgn,
    input  wire logic [63:0]           i_opa,
    input  wire logic [63:0]           i_opb,
    output tia_pkg::t_entry            o_entry
);
    import tia_pkg::*;

    logic [DataW-1:0] a, b, m, cnt, sflip, ua, ub;
    logic             big, lt_ab, lt_ba, na, nb;
    logic [5:0]       sh;

    // Extend operands and prepare the shared compare terms
    always_comb begin
        a     = ext_w(i_opa, i_wc, i_sgn);
        b     = ext_w(i_opb, i_wc, i_sgn);
        m     = mask_w(i_wc);
        cnt   = b & m;
        big   = cnt >= {57'd0, bits_w(i_wc)};
        sh    = cnt[5:0];
        sflip = {i_sgn, 63'd0};
        lt_ab = (a ^ sflip) < (b ^ sflip);
        lt_ba = (b ^ sflip) < (a ^ sflip);
        na    = i_sgn & a[63];
        nb    = i_sgn & b[63];
        ua    = na ? (64'd0 - a) : a;
        ub    = nb ? (64'd0 - b) : b;
    end

    // Classify and compute the simple result
    always_comb begin
        o_entry      = '0;
        o_entry.kind = KIND_SIMPLE;
        o_entry.wc   = i_wc;
        o_entry.sgn  = i_sgn;
        o_entry.opa  = a;
        o_entry.opb  = b;
        o_entry.ext  = (i_cmd <= CMD_SHR) || (i_cmd == CMD_CAST) ||
                       (i_cmd == CMD_BITCAST) || (i_cmd == CMD_BOX);
        unique case (i_cmd)
            CMD_ADD:    o_entry.res = a + b;
            CMD_SUB:    o_entry.res = a - b;
            CMD_MUL:    o_entry.kind = KIND_MUL;
            CMD_DIV, CMD_MOD: begin
                o_entry.kind = (i_cmd == CMD_DIV) ? KIND_DIV : KIND_MOD;
                o_entry.opa  = ua;
                o_entry.opb  = ub;
                o_entry.na   = na;
                o_entry.nb   = nb;
                o_entry.dz   = cnt == '0;
            end
            CMD_AND:    o_entry.res = a & b;
            CMD_OR:     o_entry.res = a | b;
            CMD_XOR:    o_entry.res = a ^ b;
            CMD_BITNOT: o_entry.res = ~a;
            CMD_NEG:    o_entry.res = 64'd0 - a;
            CMD_SHL:    o_entry.res = big ? '0 : (a << sh);
            CMD_SHR: begin
                if (big) begin
                    o_entry.res = na ? '1 : '0;
                end else if (na) begin
                    o_entry.res = ~((~a) >> sh);
                end else begin
                    o_entry.res = (a & m) >> sh;
                end
            end
            CMD_EQ:     o_entry.res = {63'd0, a == b};
            CMD_NE:     o_entry.res = {63'd0, a != b};
            CMD_LT:     o_entry.res = {63'd0, lt_ab};
            CMD_LE:     o_entry.res = {63'd0, !lt_ba};
            CMD_GT:     o_entry.res = {63'd0, lt_ba};
            CMD_GE:     o_entry.res = {63'd0, !lt_ab};
            CMD_LNOT:   o_entry.res = {63'd0, i_opa[7:0] == 8'd0};
            CMD_CAST:   o_entry.res = ext_w(i_opa, i_swc, i_ssgn);
            CMD_BITCAST, CMD_BOX: o_entry.res = i_opa;
            default:    o_entry.res = '0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/tia_fifo.sv
// ----------------------------------------------------------------------------
// tia_fifo
// Short request queue between the decode front and the execution pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tia_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire tia_pkg::t_entry       i_entry,
    input  wire logic                  i_pop,
    output tia_pkg::t_entry            o_head,
    output tia_pkg::t_fifo_stat        o_stat
);
    import tia_pkg::*;

    t_entry            r_mem [FifoDepth];
    logic [FifoAw-1:0] r_wptr, r_rptr;
    logic [CntW-1:0]   r_count;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = r_count == CntW'(FifoDepth);
    assign o_stat.empty = r_count == '0;

    // Write the incoming request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/tia_back.sv
// ----------------------------------------------------------------------------
// tia_back
// Execution pipeline: split 64-bit multiply over two stages, a radix-2
// divider with one quotient bit per stage, then sign fix-up and width
// extension into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tia_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tia_pkg::t_entry       i_head,
    input  wire logic                  i_avail,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [63:0]                o_result,
    output logic                       o_dz
);
    import tia_pkg::*;

    t_stage r_stg [NumStg];
    t_stage n_stg [NumStg];
    logic   adv;

    // Move the whole pipeline unless the result waits at the output
    assign adv   = !r_stg[NumStg-1].vld || i_ready;
    assign o_pop = adv && i_avail;

    // Load a request from the queue
    always_comb begin
        n_stg[0]     = '0;
        n_stg[0].vld = o_pop;
        n_stg[0].e   = i_head;
    end

    // Form the partial products of the low 64 product bits
    always_comb begin
        logic [31:0] al, ah, bl, bh;
        al = r_stg[0].e.opa[31:0];
        ah = r_stg[0].e.opa[63:32];
        bl = r_stg[0].e.opb[31:0];
        bh = r_stg[0].e.opb[63:32];
        n_stg[1] = r_stg[0];
        if (r_stg[0].e.kind == KIND_MUL) begin
            n_stg[1].e.res = {32'd0, al} * {32'd0, bl};
            n_stg[1].rem   = {32'(ah * bl), 32'(al * bh)};
        end
    end

    // Add the cross products into the upper half
    always_comb begin
        logic [31:0] xsum;
        xsum     = r_stg[1].rem[31:0] + r_stg[1].rem[63:32];
        n_stg[2] = r_stg[1];
        if (r_stg[1].e.kind == KIND_MUL) begin
            n_stg[2].e.res = r_stg[1].e.res + {xsum, 32'd0};
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < DivSteps; j++) begin : g_div
        always_comb begin
            logic [DataW:0] t, diff;
            logic           ge;
            t    = {r_stg[j+2].rem, r_stg[j+2].e.opa[DataW-1]};
            diff = t - {1'b0, r_stg[j+2].e.opb};
            ge   = t >= {1'b0, r_stg[j+2].e.opb};
            n_stg[j+3] = r_stg[j+2];
            if (r_stg[j+2].e.kind == KIND_DIV || r_stg[j+2].e.kind == KIND_MOD) begin
                n_stg[j+3].rem   = ge ? diff[DataW-1:0] : t[DataW-1:0];
                n_stg[j+3].e.opa = {r_stg[j+2].e.opa[DataW-2:0], ge};
            end
        end
    end

    // Apply signs, the zero-divisor rule and width extension
    always_comb begin
        t_stage           p;
        logic [DataW-1:0] r;
        p = r_stg[NumStg-2];
        unique case (p.e.kind)
            KIND_DIV: r = p.e.dz ? '0 :
                          ((p.e.na ^ p.e.nb) ? (64'd0 - p.e.opa) : p.e.opa);
            KIND_MOD: r = p.e.dz ? '0 : (p.e.na ? (64'd0 - p.rem) : p.rem);
            default:  r = p.e.res;
        endcase
        n_stg[NumStg-1]       = p;
        n_stg[NumStg-1].e.res = p.e.ext ? ext_w(r, p.e.wc, p.e.sgn) : r;
    end

    // Pipeline registers; only valid bits reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumStg; k++) begin
                r_stg[k].vld <= 1'b0;
            end
        end else if (adv) begin
            r_stg <= n_stg;
        end
    end

    assign o_valid  = r_stg[NumStg-1].vld;
    assign o_result = r_stg[NumStg-1].e.res;
    assign o_dz     = r_stg[NumStg-1].e.dz;

endmodule

`default_nettype wire

### hdl/typed_integer_alu_top.sv
// ----------------------------------------------------------------------------
// typed_integer_alu_top
// Typed integer ALU: 8/16/32/64-bit signed and unsigned arithmetic,
// logic, shifts, compares and casts on 64-bit value words.
//
//   channel  direction  tdata                              tuser
//   s_axis   in         command..operand_b (139 of 144b)   -
//   m_axis   out        result (64b)                       div_by_zero
//
// One request enters per cycle while the queue has room, and one result
// leaves per cycle while the output is ready. A request is registered in
// the queue, then passes through the pipeline, whose depth is set by
// the 64-step divider that every request passes through.
// Reset clears the queue and pipeline valid bits.
// A stalled output holds the pipeline; the 4-entry queue keeps taking
// requests until it fills, then o_s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "typed_integer_alu_top_assert.svh"

module typed_integer_alu_top (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // command[4:0], width_code[6:5], type_signed[7], src_width_code[9:8],
    // src_signed[10], operand_a[74:11], operand_b[138:75], zero pad
    input  wire logic [tia_pkg::InTdataW-1:0] i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // result[63:0]
    output logic [63:0]                o_m_axis_tdata,
    // div_by_zero[0]
    output logic [0:0]                 o_m_axis_tuser
);
    import tia_pkg::*;

    t_entry     w_entry, w_head;
    t_fifo_stat w_fstat;
    logic       w_push, w_pop, w_dz;

    assign o_s_axis_tready = !w_fstat.full;
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;

    // Decode and classify
    tia_front u_front (
        .i_cmd   (i_s_axis_tdata[4:0]),
        .i_wc    (i_s_axis_tdata[6:5]),
        .i_sgn   (i_s_axis_tdata[7]),
        .i_swc   (i_s_axis_tdata[9:8]),
        .i_ssgn  (i_s_axis_tdata[10]),
        .i_opa   (i_s_axis_tdata[74:11]),
        .i_opb   (i_s_axis_tdata[138:75]),
        .o_entry (w_entry)
    );

    // Queue between front and execution
    tia_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_fstat)
    );

    // Execute
    tia_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_avail  (!w_fstat.empty),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (o_m_axis_tdata),
        .o_dz     (w_dz)
    );

    assign o_m_axis_tuser = w_dz;

    `TIA_ASSERT_NOW(a_dz_zero, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == 64'd0, "zero divisor result not zero")
    `TIA_ASSERT_NOW(a_fifo_bound, 1'b1, w_fstat.count <= CntW'(FifoDepth), "queue overflow")
    `TIA_ASSERT_NOW(a_pop_nonempty, w_pop, !w_fstat.empty, "pop from empty queue")

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the typed integer ALU: random and directed
// requests, a local predictor per request, in-order result comparison.
// ----------------------------------------------------------------------------
`default_nettype none

class alu_scoreboard;
    logic [63:0] exp_res[$];
    logic        exp_dz[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    // Low w bits of v, extended by s
    static function logic [63:0] fit(logic [63:0] v, logic [1:0] wc, logic s);
        logic [63:0] m;
        m = (wc == tia_pkg::WC_64) ? '1 : ((64'd1 << (7'd8 << wc)) - 64'd1);
        v = v & m;
        if (s && wc != tia_pkg::WC_64 && v[(7'd8 << wc) - 1]) v = v | ~m;
        return v;
    endfunction

    static function logic below(logic [63:0] x, logic [63:0] y, logic s);
        if (s) return $signed(x) < $signed(y);
        return x < y;
    endfunction

    // Compute the expected result of one request
    function void note_request(logic [4:0] cmd, logic [1:0] wc, logic s,
                               logic [1:0] swc, logic ss,
                               logic [63:0] ra, logic [63:0] rb);
        logic [63:0] a, b, r, ua, ub, q, c, msk;
        logic        dz, na, nb;
        int          w;
        w = 8 << wc;
        msk = fit('1, wc, 1'b0);
        a = fit(ra, wc, s);
        b = fit(rb, wc, s);
        r = '0;
        dz = 1'b0;
        case (cmd)
            tia_pkg::CMD_ADD: r = a + b;
            tia_pkg::CMD_SUB: r = a - b;
            tia_pkg::CMD_MUL: r = a * b;
            tia_pkg::CMD_DIV, tia_pkg::CMD_MOD: begin
                if ((b & msk) == 0) begin
                    dz = 1'b1;
                end else begin
                    na = s && a[63];
                    nb = s && b[63];
                    ua = na ? -a : a;
                    ub = nb ? -b : b;
                    if (cmd == tia_pkg::CMD_DIV) begin
                        q = ua / ub;
                        r = (na != nb) ? -q : q;
                    end else begin
                        q = ua % ub;
                        r = na ? -q : q;
                    end
                end
            end
            tia_pkg::CMD_AND: r = a & b;
            tia_pkg::CMD_OR: r = a | b;
            tia_pkg::CMD_XOR: r = a ^ b;
            tia_pkg::CMD_BITNOT: r = ~a;
            tia_pkg::CMD_NEG: r = -a;
            tia_pkg::CMD_SHL: begin
                c = b & msk;
                r = (c >= w) ? '0 : (a << c);
            end
            tia_pkg::CMD_SHR: begin
                c = b & msk;
                na = s && a[63];
                if (c >= w) r = na ? '1 : '0;
                else if (na) r = ~((~a) >> c);
                else r = (a & msk) >> c;
            end
            tia_pkg::CMD_EQ: r = {63'd0, a == b};
            tia_pkg::CMD_NE: r = {63'd0, a != b};
            tia_pkg::CMD_LT: r = {63'd0, below(a, b, s)};
            tia_pkg::CMD_LE: r = {63'd0, !below(b, a, s)};
            tia_pkg::CMD_GT: r = {63'd0, below(b, a, s)};
            tia_pkg::CMD_GE: r = {63'd0, !below(a, b, s)};
            tia_pkg::CMD_LNOT: r = {63'd0, ra[7:0] == 8'd0};
            tia_pkg::CMD_CAST: r = fit(ra, swc, ss);
            tia_pkg::CMD_BITCAST, tia_pkg::CMD_BOX: r = ra;
            default: r = '0;
        endcase
        if (cmd <= tia_pkg::CMD_SHR || (cmd >= tia_pkg::CMD_CAST && cmd <= tia_pkg::CMD_BOX))
            r = fit(r, wc, s);
        exp_res.push_back(r);
        exp_dz.push_back(dz);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic [63:0] res, logic dz);
        logic [63:0] er;
        logic        ed;
        if (exp_res.size() == 0) begin
            $display("%0t: unexpected result %h dz %b", $time, res, dz);
            errors++;
            return;
        end
        er = exp_res.pop_front();
        ed = exp_dz.pop_front();
        if (res !== er) begin
            $display("%0t: result expected %h actual %h", $time, er, res);
            errors++;
        end
        if (dz !== ed) begin
            $display("%0t: div_by_zero expected %b actual %b", $time, ed, dz);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [143:0] s_data = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [63:0]  m_data;
    logic [0:0]   m_user;

    int send_idle = 6;
    int recv_idle = 73;

    alu_scoreboard sb = new();

    typed_integer_alu_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    always #10 i_clk = ~i_clk;

    // Present one request and hold it until accepted
    task automatic send_request(logic [4:0] cmd, logic [1:0] wc, logic s,
                                logic [1:0] swc, logic ss,
                                logic [63:0] a, logic [63:0] b);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {5'd0, b, a, ss, swc, s, wc, cmd};
        do @(posedge i_clk); while (!s_ready);
        sb.note_request(cmd, wc, s, swc, ss, a, b);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            2: v = 64'd1 << $urandom_range(63);
            3: v = v & 64'hFF;
            4: v = {$urandom_range(1) ? 56'hFF_FFFF_FFFF_FFFF : 56'd0, v[7:0]};
            5: v = 64'($urandom_range(70));
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_block(int n);
        logic [4:0] cmd;
        for (int i = 0; i < n; i++) begin
            cmd = ($urandom_range(19) == 0) ? 5'($urandom_range(31))
                                             : 5'($urandom_range(tia_pkg::CMD_BOX));
            send_request(cmd, 2'($urandom_range(3)), 1'($urandom_range(1)),
                         2'($urandom_range(3)), 1'($urandom_range(1)),
                         rand_operand(), rand_operand());
        end
        s_valid <= 1'b0;
    endtask

    // Receiver side: random stalls, check on every accepted result
    always @(negedge i_clk) m_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk)
        if (i_rst_n && m_valid && m_ready) sb.check_result(m_data, m_user[0]);

    initial begin
        logic [63:0] mn;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, division corners, shift limits, casts, an unused opcode
        mn = 64'h8000_0000_0000_0000;
        for (int c = tia_pkg::CMD_ADD; c <= tia_pkg::CMD_BOX; c++)
            send_request(5'(c), tia_pkg::WC_64, 1'b1, tia_pkg::WC_8, 1'b1, mn, '1);
        send_request(tia_pkg::CMD_DIV, tia_pkg::WC_8, 1'b1, tia_pkg::WC_8, 1'b0,
                     64'h80, 64'hFF);
        send_request(tia_pkg::CMD_MOD, tia_pkg::WC_16, 1'b0, tia_pkg::WC_8, 1'b0,
                     64'h1234, 64'h1_0000);
        send_request(tia_pkg::CMD_DIV, tia_pkg::WC_32, 1'b1, tia_pkg::WC_8, 1'b0,
                     64'hFFFF_FFF9, 64'd2);
        send_request(tia_pkg::CMD_SHR, tia_pkg::WC_16, 1'b1, tia_pkg::WC_8, 1'b0,
                     64'h8000, 64'd16);
        send_request(tia_pkg::CMD_SHL, tia_pkg::WC_8, 1'b0, tia_pkg::WC_8, 1'b0,
                     64'hFF, 64'd8);
        send_request(tia_pkg::CMD_CAST, tia_pkg::WC_64, 1'b0, tia_pkg::WC_16, 1'b1,
                     64'h8001, '0);
        send_request(5'd31, tia_pkg::WC_64, 1'b1, tia_pkg::WC_64, 1'b1, '1, '1);
        s_valid <= 1'b0;

        random_block(600);
        // Hold off until every expected result has arrived
        while (sb.exp_res.size() != 0) @(negedge i_clk);
        send_idle = 73;
        recv_idle = 6;
        random_block(550);
        send_idle = 0;
        recv_idle = 0;
        random_block(550);

        while (sb.exp_res.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (sb.errors == 0 && sb.exp_res.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/tia_pkg.sv
hdl/tia_front.sv
hdl/tia_fifo.sv
hdl/tia_back.sv
hdl/typed_integer_alu_top.sv
verif/tb_top.sv
